FILE: design/dpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared types and constants for the deterministic primality tester: the
// witness table, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int NUM_WIT  = 12;
    localparam int WIT_BITS = 6;
    localparam int WIDX_W   = 4;

    typedef logic [WIT_BITS-1:0] wit_t;

    localparam wit_t WITNESS [0:NUM_WIT-1] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
    };

    typedef enum logic [1:0] {
        MUL_ACC,
        MUL_BASE,
        MUL_SQX
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_MOD3,
        ST_SPLIT,
        ST_WSEL,
        ST_PBIT,
        ST_PACC,
        ST_PSQ,
        ST_PSQW,
        ST_CHECK,
        ST_SQLOOP,
        ST_SQWAIT,
        ST_SQCHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_n;
        logic     mod3_init;
        logic     mod3_step;
        logic     split_init;
        logic     split_step;
        logic     wit_init;
        logic     wit_next;
        logic     pow_init;
        logic     e_shift;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     x_wr;
        logic     base_wr;
        logic     k_init;
        logic     k_inc;
    } cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_two_three;
        logic n_even;
        logic n_lt9;
        logic scan_zero;
        logic m3_zero;
        logic d_odd;
        logic wit_end;
        logic wit_ge_n;
        logic e_zero;
        logic e_lsb;
        logic e_last;
        logic x_one;
        logic x_nm1;
        logic k_ge_r;
        logic mul_done;
    } sts_t;

endpackage
`default_nettype wire

FILE: design/dpt_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_modmul
// Iterative modular multiplier, shift-and-add, one multiplier bit per cycle.
// Operands must already be reduced below the modulus.
// ----------------------------------------------------------------------------
module dpt_modmul #(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] m,
    output logic              done,
    output logic [W-1:0]      prod
);

    logic         run_reg, run_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] y_reg, y_next;

    // Sum is kept one bit wider so that a modulus near the top of the range
    // cannot overflow.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] p,
                                             input logic [W-1:0] q,
                                             input logic [W-1:0] md);
        logic [W:0] s;
        s = {1'b0, p} + {1'b0, q};
        if (s >= {1'b0, md})
        begin
            s = s - {1'b0, md};
        end
        return s[W-1:0];
    endfunction

    assign done = run_reg && (y_reg == '0);
    assign prod = acc_reg;

    always_comb
    begin
        run_next = run_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        if (start && !run_reg)
        begin
            run_next = 1'b1;
            acc_next = '0;
            x_next   = a;
            y_next   = b;
        end
        else if (run_reg)
        begin
            if (y_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_next = add_mod(acc_reg, x_reg, m);
                end
                x_next = add_mod(x_reg, x_reg, m);
                y_next = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

endmodule
`default_nettype wire

FILE: design/dpt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_datapath
// Operand registers of the test: candidate, residue scan, 2^r*d split,
// witness index, exponentiation state and the shared modular multiplier.
// ----------------------------------------------------------------------------
module dpt_datapath #(
    parameter int W = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [63:0]   number,
    input  wire dpt_pkg::cmd_t cmd,
    output dpt_pkg::sts_t      sts
);

    localparam int RW = $clog2(W);

    logic [W-1:0]               n_reg, nm1_reg, scan_reg, d_reg, e_reg, base_reg, x_reg;
    logic [1:0]                 m3_reg;
    logic [RW-1:0]              r_reg, k_reg;
    logic [dpt_pkg::WIDX_W-1:0] widx_reg;

    logic [2:0]         m3_sum;
    logic [1:0]         m3_next;
    logic [W-1:0]       wit_val;
    logic [W-1:0]       mul_a, mul_b, prod;
    logic               mul_done;

    always_comb
    begin
        m3_sum  = {1'b0, m3_reg} + {1'b0, scan_reg[1:0]};
        m3_next = (m3_sum >= 3'd3) ? 2'(m3_sum - 3'd3) : m3_sum[1:0];
    end

    always_comb
    begin
        wit_val = '0;
        if (widx_reg < dpt_pkg::WIDX_W'(dpt_pkg::NUM_WIT))
        begin
            wit_val = {{(W-dpt_pkg::WIT_BITS){1'b0}}, dpt_pkg::WITNESS[widx_reg]};
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            dpt_pkg::MUL_ACC:
            begin
                mul_a = x_reg;
                mul_b = base_reg;
            end
            dpt_pkg::MUL_BASE:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            dpt_pkg::MUL_SQX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    dpt_modmul #(.W(W)) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .m     (n_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_n)
        begin
            n_reg <= number[W-1:0];
        end
        if (cmd.mod3_init)
        begin
            scan_reg <= n_reg;
            m3_reg   <= 2'd0;
        end
        else if (cmd.mod3_step)
        begin
            scan_reg <= scan_reg >> 2;
            m3_reg   <= m3_next;
        end
        if (cmd.split_init)
        begin
            d_reg   <= n_reg - W'(1);
            nm1_reg <= n_reg - W'(1);
            r_reg   <= '0;
        end
        else if (cmd.split_step)
        begin
            d_reg <= d_reg >> 1;
            r_reg <= r_reg + RW'(1);
        end
        if (cmd.wit_init)
        begin
            widx_reg <= '0;
        end
        else if (cmd.wit_next)
        begin
            widx_reg <= widx_reg + dpt_pkg::WIDX_W'(1);
        end
        if (cmd.pow_init)
        begin
            x_reg    <= W'(1);
            base_reg <= wit_val;
            e_reg    <= d_reg;
        end
        else
        begin
            if (cmd.e_shift)
            begin
                e_reg <= e_reg >> 1;
            end
            if (cmd.x_wr)
            begin
                x_reg <= prod;
            end
            if (cmd.base_wr)
            begin
                base_reg <= prod;
            end
        end
        if (cmd.k_init)
        begin
            k_reg <= RW'(1);
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + RW'(1);
        end
    end

    always_comb
    begin
        sts.n_lt2       = n_reg < W'(2);
        sts.n_two_three = (n_reg == W'(2)) || (n_reg == W'(3));
        sts.n_even      = !n_reg[0];
        sts.n_lt9       = n_reg < W'(9);
        sts.scan_zero   = scan_reg == '0;
        sts.m3_zero     = m3_reg == 2'd0;
        sts.d_odd       = d_reg[0];
        sts.wit_end     = widx_reg == dpt_pkg::WIDX_W'(dpt_pkg::NUM_WIT);
        sts.wit_ge_n    = wit_val >= n_reg;
        sts.e_zero      = e_reg == '0;
        sts.e_lsb       = e_reg[0];
        sts.e_last      = e_reg[W-1:1] == '0;
        sts.x_one       = x_reg == W'(1);
        sts.x_nm1       = x_reg == nm1_reg;
        sts.k_ge_r      = k_reg >= r_reg;
        sts.mul_done    = mul_done;
    end

endmodule
`default_nettype wire

FILE: design/dpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_ctrl
// Sequencer of the test: screening, residue scan, split of n-1, witness loop,
// exponentiation and squarings, plus the result register.
// ----------------------------------------------------------------------------
module dpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               prime_flag,
    input  wire dpt_pkg::sts_t sts,
    output dpt_pkg::cmd_t      cmd
);

    dpt_pkg::state_t state_reg, state_next;
    logic            verdict_reg, verdict_next;
    logic            out_valid_reg, out_valid_next;
    logic            flag_reg;
    logic            out_load;

    assign in_stall   = state_reg != dpt_pkg::ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign prime_flag = flag_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dpt_pkg::ST_SCREEN;
                end
            end
            dpt_pkg::ST_SCREEN:
            begin
                if (sts.n_lt2 || sts.n_two_three || sts.n_even || sts.n_lt9)
                begin
                    state_next = dpt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = dpt_pkg::ST_MOD3;
                end
            end
            dpt_pkg::ST_MOD3:
            begin
                if (sts.scan_zero)
                begin
                    state_next = sts.m3_zero ? dpt_pkg::ST_DONE : dpt_pkg::ST_SPLIT;
                end
            end
            dpt_pkg::ST_SPLIT:
            begin
                if (sts.d_odd)
                begin
                    state_next = dpt_pkg::ST_WSEL;
                end
            end
            dpt_pkg::ST_WSEL:
            begin
                if (sts.wit_end)
                begin
                    state_next = dpt_pkg::ST_DONE;
                end
                else if (!sts.wit_ge_n)
                begin
                    state_next = dpt_pkg::ST_PBIT;
                end
            end
            dpt_pkg::ST_PBIT:
            begin
                if (sts.e_zero)
                begin
                    state_next = dpt_pkg::ST_CHECK;
                end
                else if (sts.e_lsb)
                begin
                    state_next = dpt_pkg::ST_PACC;
                end
                else
                begin
                    state_next = dpt_pkg::ST_PSQ;
                end
            end
            dpt_pkg::ST_PACC:
            begin
                if (sts.mul_done)
                begin
                    state_next = dpt_pkg::ST_PSQ;
                end
            end
            dpt_pkg::ST_PSQ:
            begin
                state_next = sts.e_last ? dpt_pkg::ST_CHECK : dpt_pkg::ST_PSQW;
            end
            dpt_pkg::ST_PSQW:
            begin
                if (sts.mul_done)
                begin
                    state_next = dpt_pkg::ST_PBIT;
                end
            end
            dpt_pkg::ST_CHECK:
            begin
                if (sts.x_one || sts.x_nm1)
                begin
                    state_next = dpt_pkg::ST_WSEL;
                end
                else
                begin
                    state_next = dpt_pkg::ST_SQLOOP;
                end
            end
            dpt_pkg::ST_SQLOOP:
            begin
                state_next = sts.k_ge_r ? dpt_pkg::ST_DONE : dpt_pkg::ST_SQWAIT;
            end
            dpt_pkg::ST_SQWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = dpt_pkg::ST_SQCHK;
                end
            end
            dpt_pkg::ST_SQCHK:
            begin
                state_next = sts.x_nm1 ? dpt_pkg::ST_WSEL : dpt_pkg::ST_SQLOOP;
            end
            dpt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = dpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = dpt_pkg::MUL_ACC;
        verdict_next = verdict_reg;
        out_load     = 1'b0;
        case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                cmd.load_n = in_valid;
            end
            dpt_pkg::ST_SCREEN:
            begin
                cmd.mod3_init = 1'b1;
                if (sts.n_lt2)
                begin
                    verdict_next = 1'b0;
                end
                else if (sts.n_two_three)
                begin
                    verdict_next = 1'b1;
                end
                else if (sts.n_even)
                begin
                    verdict_next = 1'b0;
                end
                else
                begin
                    verdict_next = 1'b1;
                end
            end
            dpt_pkg::ST_MOD3:
            begin
                cmd.mod3_step  = !sts.scan_zero;
                cmd.split_init = sts.scan_zero;
                if (sts.scan_zero)
                begin
                    verdict_next = 1'b0;
                end
            end
            dpt_pkg::ST_SPLIT:
            begin
                cmd.split_step = !sts.d_odd;
                cmd.wit_init   = sts.d_odd;
            end
            dpt_pkg::ST_WSEL:
            begin
                if (sts.wit_end)
                begin
                    verdict_next = 1'b1;
                end
                else if (sts.wit_ge_n)
                begin
                    cmd.wit_next = 1'b1;
                end
                else
                begin
                    cmd.pow_init = 1'b1;
                end
            end
            dpt_pkg::ST_PBIT:
            begin
                cmd.mul_sel   = dpt_pkg::MUL_ACC;
                cmd.mul_start = !sts.e_zero && sts.e_lsb;
            end
            dpt_pkg::ST_PACC:
            begin
                cmd.x_wr = sts.mul_done;
            end
            dpt_pkg::ST_PSQ:
            begin
                // The last exponent bit needs no further squaring of the base.
                cmd.e_shift   = 1'b1;
                cmd.mul_sel   = dpt_pkg::MUL_BASE;
                cmd.mul_start = !sts.e_last;
            end
            dpt_pkg::ST_PSQW:
            begin
                cmd.base_wr = sts.mul_done;
            end
            dpt_pkg::ST_CHECK:
            begin
                cmd.wit_next = sts.x_one || sts.x_nm1;
                cmd.k_init   = !(sts.x_one || sts.x_nm1);
            end
            dpt_pkg::ST_SQLOOP:
            begin
                cmd.mul_sel   = dpt_pkg::MUL_SQX;
                cmd.mul_start = !sts.k_ge_r;
                if (sts.k_ge_r)
                begin
                    verdict_next = 1'b0;
                end
            end
            dpt_pkg::ST_SQWAIT:
            begin
                cmd.x_wr  = sts.mul_done;
                cmd.k_inc = sts.mul_done;
            end
            dpt_pkg::ST_SQCHK:
            begin
                cmd.wit_next = sts.x_nm1;
            end
            dpt_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        if (out_load)
        begin
            flag_reg <= verdict_reg;
        end
    end

endmodule
`default_nettype wire

FILE: design/deterministic_primality_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deterministic_primality_test
// Miller-Rabin test with witnesses 2..37, exact for every WIDTH-bit candidate.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  number     [63:0], low WIDTH bits used
//   out      out_valid/ out_stall prime_flag [0]
//
// One item is worked on at a time; small and even candidates finish at the
// screening step, multiples of 3 after the residue mod 3 scan, and the rest go
// on to split n-1. Each modular product is formed in the single shift-and-add
// multiplier, and a witness needs at most about 2*WIDTH products.
// The next item is taken while a finished result still waits on out_stall.
// Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
module deterministic_primality_test #(
    parameter int WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] number,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             prime_flag
);

    dpt_pkg::cmd_t cmd;
    dpt_pkg::sts_t sts;

    dpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prime_flag (prime_flag),
        .sts        (sts),
        .cmd        (cmd)
    );

    dpt_datapath #(.W(WIDTH)) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule
`default_nettype wire
